>>> rtl/nnls_pkg.sv
// ----------------------------------------------------------------------------
// nnls_pkg
// Shared constants, codes and types of the nearest-neighbour linear search.
// ----------------------------------------------------------------------------
`default_nettype none

package nnls_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_DIM     = 16;

	// port widths
	localparam int KIND_W    = 2;
	localparam int ENTRY_W   = 10;
	localparam int DIMIDX_W  = 4;
	localparam int ELEM_W    = 8;
	localparam int DIMS_W    = 5;
	localparam int COUNT_W   = 11;
	localparam int MODE_W    = 1;
	localparam int BEST_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;

	// internal widths
	localparam int ENT_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DCNT_W  = $clog2(MAX_DIM + 1);
	localparam int MEM_DEPTH = MAX_ENTRIES * MAX_DIM;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int TERM_W  = 2 * ELEM_W;
	localparam int RAW_W   = $clog2(MAX_DIM * 65025 + 1);
	localparam int DIST_W  = (RAW_W > BEST_W) ? RAW_W : BEST_W;

	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'((64'd1 << BEST_W) - 64'd1);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_MODE   = 2'd2;

	// distance modes
	localparam logic [MODE_W-1:0] MODE_EUCLID_SQ = 1'b0;
	localparam logic [MODE_W-1:0] MODE_MANHATTAN = 1'b1;

	typedef struct packed {
		logic              ds_we;
		logic              q_we;
		logic [ADDR_W-1:0] ds_addr;
		logic [DIM_W-1:0]  q_addr;
		logic [ELEM_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] ds_addr;
		logic [DIM_W-1:0]  q_addr;
	} mem_rd_t;

endpackage

`default_nettype wire

>>> rtl/nnls_store.sv
// ----------------------------------------------------------------------------
// nnls_store
// Dataset memory and query vector memory, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
`default_nettype none

module nnls_store
	import nnls_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_wr_t           wr,
	input  wire mem_rd_t           rd,
	output logic      [ELEM_W-1:0] ds_rdata,
	output logic      [ELEM_W-1:0] q_rdata
);

	logic [ELEM_W-1:0] ds_mem [MEM_DEPTH];
	logic [ELEM_W-1:0] q_mem  [MAX_DIM];

	always_ff @(posedge clk) begin
		if (wr.ds_we) begin
			ds_mem[wr.ds_addr] <= wr.data;
		end
		if (rd.en) begin
			ds_rdata <= ds_mem[rd.ds_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.q_we) begin
			q_mem[wr.q_addr] <= wr.data;
		end
		if (rd.en) begin
			q_rdata <= q_mem[rd.q_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/nnls_search.sv
// ----------------------------------------------------------------------------
// nnls_search
// Search sequencer: walks every element of every entry, accumulates the
// distance through a short pipeline and keeps the running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module nnls_search
	import nnls_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic  [DIMS_W-1:0]   dimensions,
	input  wire logic  [COUNT_W-1:0]  entry_count,
	input  wire logic  [MODE_W-1:0]   distance_mode,
	output mem_rd_t                   rd,
	input  wire logic  [ELEM_W-1:0]   ds_rdata,
	input  wire logic  [ELEM_W-1:0]   q_rdata,
	output logic                      busy,
	output logic                      done,
	output logic       [ENTRY_W-1:0]  nearest_index,
	output logic       [BEST_W-1:0]   best_distance,
	output logic                      found
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    ent_q;
	logic [DIM_W-1:0]    dim_q;
	logic [CNT_W-1:0]    count_q;
	logic [DCNT_W-1:0]   nd_q;
	logic                zero_q;
	logic [MODE_W-1:0]   mode_q;
	logic                have_q;
	logic [DIST_W-1:0]   best_q;
	logic [ENT_W-1:0]    bidx_q;
	logic [DIST_W-1:0]   acc_q;
	logic                done_q;
	logic                found_q;
	logic [ENTRY_W-1:0]  idx_q;
	logic [BEST_W-1:0]   dist_q;

	logic                v_s1, first_s1, last_s1;
	logic [ENT_W-1:0]    ent_s1;
	logic                v_s2, first_s2, last_s2;
	logic [ENT_W-1:0]    ent_s2;
	logic [TERM_W-1:0]   term_s2;

	logic [CNT_W-1:0]    count_eff;
	logic [DCNT_W-1:0]   dims_eff;
	logic                last_dim, last_ent;
	logic [ELEM_W-1:0]   diff;
	logic [TERM_W-1:0]   term;
	logic [DIST_W-1:0]   sum;
	logic                better;
	logic [DIST_W-1:0]   best_sat;

	assign count_eff = (32'(entry_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
	                                                    : CNT_W'(entry_count);
	assign dims_eff  = (32'(dimensions) > MAX_DIM) ? DCNT_W'(MAX_DIM)
	                                               : DCNT_W'(dimensions);

	assign last_dim = (DCNT_W'(dim_q) + DCNT_W'(1)) == nd_q;
	assign last_ent = (ent_q + CNT_W'(1)) == count_q;

	assign rd.en      = (state_q == S_RUN);
	assign rd.ds_addr = ADDR_W'(ent_q[ENT_W-1:0]) * ADDR_W'(MAX_DIM) + ADDR_W'(dim_q);
	assign rd.q_addr  = dim_q;

	// distance term
	always_comb begin
		diff = (q_rdata >= ds_rdata) ? (q_rdata - ds_rdata) : (ds_rdata - q_rdata);
		if (zero_q) begin
			term = '0;
		end else if (mode_q == MODE_MANHATTAN) begin
			term = TERM_W'(diff);
		end else begin
			term = TERM_W'(diff) * TERM_W'(diff);
		end
	end

	assign sum      = (first_s2 ? '0 : acc_q) + DIST_W'(term_s2);
	assign better   = !have_q || (sum < best_q);
	assign best_sat = (best_q > DIST_MAX) ? DIST_MAX : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_RUN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (dim_q == '0);
		last_s1  <= last_dim;
		ent_s1   <= ent_q[ENT_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ent_s2   <= ent_s1;
		term_s2  <= term;
		if (v_s2) begin
			acc_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ent_q   <= '0;
			dim_q   <= '0;
			count_q <= '0;
			nd_q    <= '0;
			zero_q  <= 1'b0;
			mode_q  <= MODE_EUCLID_SQ;
			have_q  <= 1'b0;
			best_q  <= '0;
			bidx_q  <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
			dist_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (v_s2 && last_s2 && better) begin
				best_q <= sum;
				bidx_q <= ent_s2;
				have_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						if (count_eff == '0) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
							idx_q   <= '0;
							dist_q  <= '0;
						end else begin
							state_q <= S_RUN;
							ent_q   <= '0;
							dim_q   <= '0;
							count_q <= count_eff;
							nd_q    <= (dims_eff == '0) ? DCNT_W'(1) : dims_eff;
							zero_q  <= (dims_eff == '0);
							mode_q  <= distance_mode;
							have_q  <= 1'b0;
						end
					end
				end
				S_RUN: begin
					if (last_dim) begin
						dim_q <= '0;
						ent_q <= ent_q + CNT_W'(1);
						if (last_ent) begin
							state_q <= S_DRAIN;
						end
					end else begin
						dim_q <= dim_q + DIM_W'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						found_q <= have_q;
						idx_q   <= ENTRY_W'(bidx_q);
						dist_q  <= best_sat[BEST_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign found         = found_q;
	assign nearest_index = idx_q;
	assign best_distance = dist_q;

endmodule

`default_nettype wire

>>> rtl/nearest_neighbor_linear_search.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_linear_search
// Brute-force nearest-neighbour search over stored byte vectors, squared
// Euclidean or Manhattan distance.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  item      start, busy           kind, entry_index, dim_index, element_value
//  result    done (one cycle)      nearest_index, best_distance, found
//  config    cfg_valid, cfg_ready  cfg_index, cfg_data
//
//  load items leave busy low
//  a search holds busy high while it reads entries * max(dimensions,1) elements, one element
//  per cycle through the single read port; entries and dimensions capped at the store
//  done comes in the same cycle as busy falls; an empty search answers in the next cycle
//  done is high for one cycle and cannot be held off; cfg_ready is always high
//  reset is asynchronous; the memories are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_linear_search
	import nnls_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic  [KIND_W-1:0]    kind,
	input  wire logic  [ENTRY_W-1:0]   entry_index,
	input  wire logic  [DIMIDX_W-1:0]  dim_index,
	input  wire logic  [ELEM_W-1:0]    element_value,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic  [CFG_IDX_W-1:0] cfg_index,
	input  wire logic  [CFG_DAT_W-1:0] cfg_data,
	output logic                       done,
	output logic       [ENTRY_W-1:0]   nearest_index,
	output logic       [BEST_W-1:0]    best_distance,
	output logic                       found
);

	logic [DIMS_W-1:0]  dimensions_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [MODE_W-1:0]  distance_mode_q;

	logic              accept;
	mem_wr_t           wr;
	mem_rd_t           rd;
	logic [ELEM_W-1:0] ds_rdata, q_rdata;
	logic              ent_ok, dim_ok;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q    <= DIMS_W'(2);
			entry_count_q   <= '0;
			distance_mode_q <= MODE_EUCLID_SQ;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIMENSIONS:  dimensions_q    <= cfg_data[DIMS_W-1:0];
				REG_ENTRY_COUNT: entry_count_q   <= cfg_data[COUNT_W-1:0];
				REG_DIST_MODE:   distance_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign ent_ok = 32'(entry_index) < MAX_ENTRIES;
	assign dim_ok = 32'(dim_index) < MAX_DIM;

	always_comb begin
		wr.ds_we   = accept && (kind == KIND_DATA) && ent_ok && dim_ok;
		wr.q_we    = accept && (kind == KIND_QUERY) && dim_ok;
		wr.ds_addr = ADDR_W'(entry_index) * ADDR_W'(MAX_DIM) + ADDR_W'(dim_index);
		wr.q_addr  = DIM_W'(dim_index);
		wr.data    = element_value;
	end

	nnls_store u_store (
		.clk      (clk),
		.wr       (wr),
		.rd       (rd),
		.ds_rdata (ds_rdata),
		.q_rdata  (q_rdata)
	);

	nnls_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (accept && (kind == KIND_SEARCH)),
		.dimensions    (dimensions_q),
		.entry_count   (entry_count_q),
		.distance_mode (distance_mode_q),
		.rd            (rd),
		.ds_rdata      (ds_rdata),
		.q_rdata       (q_rdata),
		.busy          (busy),
		.done          (done),
		.nearest_index (nearest_index),
		.best_distance (best_distance),
		.found         (found)
	);

endmodule

`default_nettype wire

>>> rtl/nnls_checker.sv
// ----------------------------------------------------------------------------
// nnls_checker
// Port-level checks of the nearest-neighbour search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnls_checker
	import nnls_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic  [KIND_W-1:0]    kind,
	input wire logic                  done,
	input wire logic  [ENTRY_W-1:0]   nearest_index,
	input wire logic  [BEST_W-1:0]    best_distance,
	input wire logic                  found
);

	// a search either runs or answers at once
	a_search_acts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_SEARCH |=> busy || done)
		else $error("search item neither started nor answered");

	// load items never produce a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind != KIND_SEARCH |=> !done)
		else $error("result after a load item");

	// end of a search delivers its result
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search ended without a result");

	// empty search reports zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> nearest_index == '0 && best_distance == '0)
		else $error("empty search result not zero");

endmodule

bind nearest_neighbor_linear_search nnls_checker u_nnls_checker (.*);

`default_nettype wire
